@@ rtl/mie_pkg.sv @@
// Shared types and constants for the modular inverse block.
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

    // Operand and modulus width
    localparam int VAL_W      = 63;
    // Width of the signed difference and of the Bezout coefficients
    localparam int DATA_WIDTH = 64;
    // Quotient bit counter, enough for shifts up to VAL_W - 1
    localparam int K_W        = $clog2(VAL_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SUB,
        ST_FIX,
        ST_DONE
    } mie_state_t;

    // Operands for the shared compare/subtract unit
    typedef struct packed {
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic [DATA_WIDTH-1:0] ta;
        logic [DATA_WIDTH-1:0] tb;
    } mie_op_t;

    // Results of the shared compare/subtract unit
    typedef struct packed {
        logic                  ge;
        logic [DATA_WIDTH-1:0] diff;
        logic [DATA_WIDTH-1:0] tdiff;
    } mie_res_t;

endpackage

`default_nettype wire

@@ rtl/modular_inverse_ext_euclid_top.sv @@
// Top level of the modular inverse block: modulus register, core and output register.
//
// Usage: write the modulus on the cfg channel (cfg_valid/cfg_ready, data on
// modulus) while the block is idle; cfg_ready is always high. Items enter on
// in_valid/in_stall with operand_value and are accepted when in_valid is high
// and in_stall low. Each item yields one result on out_valid/out_stall with
// mult_inverse, inverse_exists and additive_inverse.
// Each Euclid round doubles the divisor until the next doubling would pass the
// remainder, then does one conditional subtract per quotient bit. The shared
// compare/subtract unit does one doubling or one conditional subtract per
// cycle. in_stall is high while an item is in work.
// A finished result waits in the output register; the core accepts the next
// item as soon as it has handed its result over, so a stalled receiver only
// holds the block when a second result is ready behind the first.
// Reset clears all valids and sets the modulus to 1.
`timescale 1ns / 1ps
`default_nettype none

module modular_inverse_ext_euclid_top
    import mie_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [VAL_W-1:0]         modulus,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [VAL_W-1:0]         operand_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [VAL_W-1:0]              mult_inverse,
    output logic                          inverse_exists,
    output logic signed [DATA_WIDTH-1:0]  additive_inverse
);

    logic [VAL_W-1:0]              modulus_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]              inv_reg;
    logic                          exists_reg;
    logic signed [DATA_WIDTH-1:0]  add_reg;

    logic                          busy;
    logic                          start;
    logic                          take;
    logic                          done_valid;
    logic [VAL_W-1:0]              res_inverse;
    logic                          res_exists;
    logic signed [DATA_WIDTH-1:0]  res_additive;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign start     = in_valid && !busy;
    // Hand over a result when the output register is free or draining
    assign take      = done_valid && (!out_valid_reg || !out_stall);

    mie_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .value        (operand_value),
        .modulus      (modulus_reg),
        .take         (take),
        .busy         (busy),
        .done_valid   (done_valid),
        .res_inverse  (res_inverse),
        .res_exists   (res_exists),
        .res_additive (res_additive)
    );

    // Hold the modulus
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= {{(VAL_W-1){1'b0}}, 1'b1};
        else if (cfg_valid && cfg_ready)
            modulus_reg <= modulus;
    end

    // Output valid: set on handover, drop when the item is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            inv_reg    <= res_inverse;
            exists_reg <= res_exists;
            add_reg    <= res_additive;
        end
    end

    assign out_valid        = out_valid_reg;
    assign mult_inverse     = inv_reg;
    assign inverse_exists   = exists_reg;
    assign additive_inverse = add_reg;

endmodule

`default_nettype wire

@@ rtl/mie_step_unit.sv @@
// Shared compare and subtract unit for remainder and coefficient updates.
`timescale 1ns / 1ps
`default_nettype none

module mie_step_unit
    import mie_pkg::*;
(
    input  wire mie_op_t op,
    output mie_res_t     res
);

    // Unsigned compare of the remainder side, subtract on both sides
    always_comb
    begin
        res.ge    = (op.a >= op.b);
        res.diff  = op.a - op.b;
        res.tdiff = op.ta - op.tb;
    end

endmodule

`default_nettype wire

@@ rtl/mie_core.sv @@
// Sequencer for the extended Euclidean algorithm with shift-subtract division.
`timescale 1ns / 1ps
`default_nettype none

module mie_core
    import mie_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [VAL_W-1:0]             value,
    input  wire logic [VAL_W-1:0]             modulus,
    input  wire logic                         take,
    output logic                              busy,
    output logic                              done_valid,
    output logic [VAL_W-1:0]                  res_inverse,
    output logic                              res_exists,
    output logic signed [DATA_WIDTH-1:0]      res_additive
);

    mie_state_t             state_reg, state_next;
    logic [VAL_W-1:0]       r_prev_reg, r_prev_next;
    logic [VAL_W-1:0]       r_cur_reg, r_cur_next;
    logic [DATA_WIDTH-1:0]  t_prev_reg, t_prev_next;
    logic [DATA_WIDTH-1:0]  t_cur_reg, t_cur_next;
    logic [VAL_W-1:0]       d_reg, d_next;
    logic [DATA_WIDTH-1:0]  td_reg, td_next;
    logic [K_W-1:0]         k_reg, k_next;
    logic                   ok_reg, ok_next;
    logic [DATA_WIDTH-1:0]  add_reg, add_next;

    mie_op_t                op;
    mie_res_t               res;
    logic [VAL_W-1:0]       rp_new;
    logic [DATA_WIDTH-1:0]  tp_new;
    logic [DATA_WIDTH-1:0]  m_ext;

    assign m_ext = {1'b0, modulus};

    mie_step_unit u_step (
        .op  (op),
        .res (res)
    );

    // Route operands into the shared unit by phase
    always_comb
    begin
        op.a  = {1'b0, r_prev_reg};
        op.b  = {1'b0, d_reg};
        op.ta = t_prev_reg;
        op.tb = td_reg;
        case (state_reg)
            ST_ALIGN:
            begin
                op.b = {d_reg, 1'b0};
            end
            ST_DONE:
            begin
                op.a  = t_prev_reg;
                op.b  = m_ext;
            end
            default:
            begin
                op.b = {1'b0, d_reg};
            end
        endcase
    end

    // Conditional subtract of the shifted divisor
    assign rp_new = res.ge ? res.diff[VAL_W-1:0] : r_prev_reg;
    assign tp_new = res.ge ? res.tdiff : t_prev_reg;

    // Next state and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        r_prev_next = r_prev_reg;
        r_cur_next  = r_cur_reg;
        t_prev_next = t_prev_reg;
        t_cur_next  = t_cur_reg;
        d_next      = d_reg;
        td_next     = td_reg;
        k_next      = k_reg;
        ok_next     = ok_reg;
        add_next    = add_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    r_prev_next = modulus;
                    r_cur_next  = value;
                    t_prev_next = '0;
                    t_cur_next  = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
                    d_next      = value;
                    td_next     = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
                    k_next      = '0;
                    add_next    = m_ext - {1'b0, value};
                    if ((modulus == '0) || (value == '0))
                        state_next = ST_FIX;
                    else
                        state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                // Double the divisor while it still fits under the remainder
                if (res.ge)
                begin
                    d_next  = {d_reg[VAL_W-2:0], 1'b0};
                    td_next = {td_reg[DATA_WIDTH-2:0], 1'b0};
                    k_next  = k_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                if (k_reg == '0)
                begin
                    // Last quotient bit: rotate the remainder sequence
                    r_prev_next = r_cur_reg;
                    r_cur_next  = rp_new;
                    t_prev_next = t_cur_reg;
                    t_cur_next  = tp_new;
                    d_next      = rp_new;
                    td_next     = tp_new;
                    if (rp_new == '0)
                        state_next = ST_FIX;
                    else
                        state_next = ST_ALIGN;
                end
                else
                begin
                    r_prev_next = rp_new;
                    t_prev_next = tp_new;
                    d_next      = {1'b0, d_reg[VAL_W-1:1]};
                    td_next     = {td_reg[DATA_WIDTH-1], td_reg[DATA_WIDTH-1:1]};
                    k_next      = k_reg - 1'b1;
                end
            end
            ST_FIX:
            begin
                // Gcd sits in r_prev; move a negative coefficient into range
                ok_next = (r_prev_reg == {{(VAL_W-1){1'b0}}, 1'b1}) && (modulus != '0);
                if (t_prev_reg[DATA_WIDTH-1])
                    t_prev_next = t_prev_reg + m_ext;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        r_prev_reg <= r_prev_next;
        r_cur_reg  <= r_cur_next;
        t_prev_reg <= t_prev_next;
        t_cur_reg  <= t_cur_next;
        d_reg      <= d_next;
        td_reg     <= td_next;
        k_reg      <= k_next;
        ok_reg     <= ok_next;
        add_reg    <= add_next;
    end

    // Final reduction into 0..modulus-1
    assign busy         = (state_reg != ST_IDLE);
    assign done_valid   = (state_reg == ST_DONE);
    assign res_exists   = ok_reg;
    assign res_inverse  = ok_reg ? (res.ge ? res.diff[VAL_W-1:0] : t_prev_reg[VAL_W-1:0])
                                 : '0;
    assign res_additive = $signed(add_reg);

endmodule

`default_nettype wire

@@ bench/mie_checker.sv @@
// Checker for the modular inverse block: predicts each result and compares it field by field.
`timescale 1ns / 1ps

module mie_checker
    import mie_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_ready,
    input  wire logic [VAL_W-1:0]        modulus,
    input  wire logic                    in_valid,
    input  wire logic                    in_stall,
    input  wire logic [VAL_W-1:0]        operand_value,
    input  wire logic                    out_valid,
    input  wire logic                    out_stall,
    input  wire logic [VAL_W-1:0]        mult_inverse,
    input  wire logic                    inverse_exists,
    input  wire logic [DATA_WIDTH-1:0]   additive_inverse,
    output int                           mismatch_count,
    output int                           inverses_outstanding
);

    typedef struct {
        logic [VAL_W-1:0]      inverse;
        logic                  exists;
        logic [DATA_WIDTH-1:0] difference;
    } inverse_item_t;

    inverse_item_t    inverse_queue[$];
    logic [VAL_W-1:0] modulus_copy;

    initial
    begin
        mismatch_count       = 0;
        inverses_outstanding = 0;
        modulus_copy         = VAL_W'(1);
    end

    // Extended Euclid on the value's Bezout coefficient, 64-bit wrapping
    function automatic inverse_item_t predict_inverse(input logic [VAL_W-1:0] value,
                                                      input logic [VAL_W-1:0] m);
        inverse_item_t         res;
        logic [63:0]           r_prev;
        logic [63:0]           r_cur;
        logic [63:0]           r_next;
        logic [63:0]           quot;
        logic [63:0]           t_prev;
        logic [63:0]           t_cur;
        logic [63:0]           t_next;
        res.difference = {1'b0, m} - {1'b0, value};
        res.inverse    = '0;
        res.exists     = 1'b0;
        // Zero modulus has no inverse at all
        if (m != 0)
        begin
            r_prev = {1'b0, m};
            r_cur  = {1'b0, value} % {1'b0, m};
            t_prev = 64'd0;
            t_cur  = 64'd1;
            while (r_cur != 0)
            begin
                quot   = r_prev / r_cur;
                r_next = r_prev - quot * r_cur;
                t_next = t_prev - quot * t_cur;
                r_prev = r_cur;
                r_cur  = r_next;
                t_prev = t_cur;
                t_cur  = t_next;
            end
            if (r_prev == 64'd1)
            begin
                res.exists = 1'b1;
                // Fold a negative coefficient back into range
                if (t_prev[63])
                    t_prev = {1'b0, m} + t_prev;
                if (m != 1)
                    res.inverse = VAL_W'(t_prev % {1'b0, m});
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch in %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Watch all three channels; pop results before pushing new items
    always @(posedge clk or negedge rst_n)
    begin : watch
        inverse_item_t want;
        if (!rst_n)
        begin
            modulus_copy = VAL_W'(1);
            inverse_queue.delete();
            inverses_outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (inverse_queue.size() == 0)
                    report_mismatch("result with no item waiting", {1'b0, mult_inverse},
                                    64'd0);
                else
                begin
                    want = inverse_queue.pop_front();
                    if (mult_inverse !== want.inverse)
                        report_mismatch("mult_inverse", {1'b0, mult_inverse},
                                        {1'b0, want.inverse});
                    if (inverse_exists !== want.exists)
                        report_mismatch("inverse_exists", {63'd0, inverse_exists},
                                        {63'd0, want.exists});
                    if (additive_inverse !== want.difference)
                        report_mismatch("additive_inverse", additive_inverse,
                                        want.difference);
                end
            end
            if (in_valid && !in_stall)
                inverse_queue.push_back(predict_inverse(operand_value, modulus_copy));
            if (cfg_valid && cfg_ready)
                modulus_copy = modulus;
            inverses_outstanding <= inverse_queue.size();
        end
    end

endmodule

@@ bench/tb_modular_inverse_ext_euclid_top.sv @@
// Testbench top for the modular inverse block: stimulus, stall control and verdict.
`timescale 1ns / 1ps

module tb_modular_inverse_ext_euclid_top;
    import mie_pkg::*;

    localparam logic [VAL_W-1:0] MAX_VAL   = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] PRIME_61  = 63'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] POW2_62   = 63'h4000_0000_0000_0000;
    localparam int               ITEMS_PER_MODULUS = 76;
    localparam int               HOLD_CYCLES       = 2000;
    localparam int               DRAIN_CYCLES      = 400;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [VAL_W-1:0]        modulus;
    logic                    in_valid;
    logic                    in_stall;
    logic [VAL_W-1:0]        operand_value;
    logic                    out_valid;
    logic                    out_stall;
    logic [VAL_W-1:0]        mult_inverse;
    logic                    inverse_exists;
    logic [DATA_WIDTH-1:0]   additive_inverse;

    int                      mismatch_count;
    int                      inverses_outstanding;
    int                      send_idle_pct;
    int                      recv_idle_pct;
    int                      hold_left;
    logic                    hold_go;
    logic                    hold_done;
    logic [VAL_W-1:0]        current_modulus;

    modular_inverse_ext_euclid_top u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .modulus          (modulus),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operand_value    (operand_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .mult_inverse     (mult_inverse),
        .inverse_exists   (inverse_exists),
        .additive_inverse (additive_inverse)
    );

    mie_checker u_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .modulus              (modulus),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .operand_value        (operand_value),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .mult_inverse         (mult_inverse),
        .inverse_exists       (inverse_exists),
        .additive_inverse     (additive_inverse),
        .mismatch_count       (mismatch_count),
        .inverses_outstanding (inverses_outstanding)
    );

    // Free-running clock, 4 ns period
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Give up well past the slowest legal run
    initial
    begin
        #(4 * 3_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [VAL_W-1:0] random_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[VAL_W-1:0];
    endfunction

    // Pick a modulus for one setting, extremes included
    function automatic logic [VAL_W-1:0] pick_modulus(input int idx);
        logic [VAL_W-1:0] m;
        case (idx)
            0: m = MAX_VAL;
            1: m = VAL_W'(1);
            2: m = VAL_W'(2);
            3: m = PRIME_61;
            4: m = POW2_62;
            5: m = VAL_W'($urandom_range(3, 5000));
            default:
            begin
                m = random_value() >> $urandom_range(0, 40);
                if (m == 0)
                    m = VAL_W'(3);
            end
        endcase
        return m;
    endfunction

    // Mix of wide, narrow, even, reduced and out-of-range operands
    function automatic logic [VAL_W-1:0] make_operand(input logic [VAL_W-1:0] m);
        logic [VAL_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = random_value();
            3, 4:    v = random_value() >> $urandom_range(1, 62);
            5:       v = (m != 0) ? random_value() % m : random_value();
            6:       v = (random_value() >> $urandom_range(0, 62)) & ~VAL_W'(1);
            7:       v = m + VAL_W'($urandom_range(0, 1000));
            8:       v = m - VAL_W'($urandom_range(1, 1000));
            default:
            begin
                case ($urandom_range(2))
                    0:       v = '0;
                    1:       v = VAL_W'(1);
                    default: v = MAX_VAL;
                endcase
            end
        endcase
        return v;
    endfunction

    // Offer one item, with random idle cycles ahead of it
    task automatic send_item(input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        operand_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drain all results, then load a new modulus
    task automatic write_modulus(input logic [VAL_W-1:0] m);
        in_valid <= 1'b0;
        @(posedge clk);
        while (inverses_outstanding != 0)
            @(posedge clk);
        cfg_valid       <= 1'b1;
        modulus         <= m;
        current_modulus = m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        modulus         = '0;
        in_valid        = 1'b0;
        operand_value   = '0;
        hold_go         = 1'b0;
        send_idle_pct   = 10;
        recv_idle_pct   = 54;
        current_modulus = VAL_W'(1);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset modulus of one: every value inverts to zero
        send_item('0);
        send_item(MAX_VAL);
        send_item(VAL_W'(5));

        // Largest modulus, composite: zero, one, value equal to modulus, shared factor
        write_modulus(MAX_VAL);
        send_item('0);
        send_item(VAL_W'(1));
        send_item(VAL_W'(2));
        send_item(MAX_VAL);
        send_item(MAX_VAL - 1);
        send_item(POW2_62);
        send_item(63'h2AAA_AAAA_AAAA_AAAA);
        send_item(VAL_W'(7));

        // Prime modulus with values above it: reduced first, negative difference
        write_modulus(PRIME_61);
        send_item(MAX_VAL);
        send_item(PRIME_61 + 1);
        send_item(VAL_W'(12345));

        // Even modulus
        write_modulus(VAL_W'(2));
        send_item(VAL_W'(1));
        send_item(VAL_W'(4));
        send_item(VAL_W'(3));

        // Zero modulus: never an inverse, difference still formed
        write_modulus('0);
        send_item('0);
        send_item(VAL_W'(9));
        send_item(MAX_VAL);

        // Random part: three stall profiles, seven moduli each
        for (int phase = 0; phase < 3; phase++)
        begin
            write_modulus(current_modulus);
            case (phase)
                0:
                begin
                    send_idle_pct = 10;
                    recv_idle_pct <= 54;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_idle_pct <= 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int setting = 0; setting < 7; setting++)
            begin
                write_modulus(pick_modulus(setting));
                // Long receiver hold-off while the sender keeps offering
                if (phase == 2 && setting == 3)
                    hold_go <= 1'b1;
                repeat (ITEMS_PER_MODULUS)
                    send_item(make_operand(current_modulus));
            end
        end
        in_valid <= 1'b0;

        // Wait for the last results, then watch for strays
        @(posedge clk);
        while (inverses_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
